// ===== rtl/rbme_pkg.sv =====
// Package with shared constants and types for the RSA byte exponentiation block.
`timescale 1ns / 1ps

package rbme_pkg;

   localparam int DEF_MOD_WIDTH = 32;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_INDEX_W   = 8;
   localparam int CHAR_W        = 8;
   localparam int CIPHER_W      = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_EXPONENT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULUS  = 8'd1;

   localparam logic [CSR_DATA_W-1:0] RST_EXPONENT = 32'd3;
   localparam logic [CSR_DATA_W-1:0] RST_MODULUS  = 32'd3233;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE,
      ST_SQR,
      ST_MUL,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/rbme_mulmod.sv =====
// Bit-serial modular multiplier using shift-and-add with conditional subtraction.
`timescale 1ns / 1ps

module rbme_mulmod #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  logic [WIDTH-1:0] modulus,
   output logic             done,
   output logic [WIDTH-1:0] prod
);

   import rbme_pkg::*;

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             add_ff, add_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [WIDTH-1:0] operand;
   logic [WIDTH:0]   sum;
   logic [WIDTH+1:0] diff;
   logic [WIDTH-1:0] reduced;

   assign operand = add_ff ? a_ff : acc_ff;
   assign sum     = {1'b0, acc_ff} + {1'b0, operand};
   assign diff    = {1'b0, sum} - {2'b00, modulus};
   assign reduced = diff[WIDTH+1] ? sum[WIDTH-1:0] : diff[WIDTH-1:0];

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      add_in  = add_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = a;
         b_in    = b;
         cnt_in  = CNT_W'(WIDTH);
         add_in  = 1'b0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = reduced;
         if (!add_ff && b_ff[WIDTH-1]) begin
            add_in = 1'b1;
         end else begin
            add_in = 1'b0;
            b_in   = b_ff << 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
      add_ff <= add_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ===== rtl/rsa_byte_modular_exponentiation_top.sv =====
// Top level of the RSA byte exponentiation block: control sequencer and registers.
//
//   Channel   Direction   Handshake              Beat contents
//   req_      in          req_valid/req_stall    plain_char, last_char
//   rsp_      out         rsp_valid/rsp_stall    cipher_value, last_out
//   csr_      in          csr_valid/csr_ready    index, data
//
// One character is processed at a time. With W = min(MOD_WIDTH, 32), the character is first
// reduced by one modular product, then W squarings and one product per set exponent bit follow.
// A modulus below two gives a zero result without any product. Each product runs bit-serially
// in the multiplier, one multiplier bit at a time, with an extra add step for each set bit.
// Reset is synchronous and active high. A finished beat waits in the output register while
// rsp_stall is high, and the next character is accepted meanwhile.
`timescale 1ns / 1ps

module rsa_byte_modular_exponentiation_top #(
   parameter int MOD_WIDTH = rbme_pkg::DEF_MOD_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [rbme_pkg::CHAR_W-1:0]       req_plain_char,
   input  logic                              req_last_char,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rbme_pkg::CIPHER_W-1:0]     rsp_cipher_value,
   output logic                              rsp_last_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rbme_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rbme_pkg::CSR_DATA_W-1:0]   csr_data
);

   import rbme_pkg::*;

   localparam int REG_W = (MOD_WIDTH < CSR_DATA_W) ? MOD_WIDTH : CSR_DATA_W;
   localparam int CNT_W = $clog2(REG_W + 1);

   state_type        state_ff, state_in;
   logic [REG_W-1:0] exponent_ff;
   logic [REG_W-1:0] modulus_ff;
   logic [REG_W-1:0] exp_ff, exp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [REG_W-1:0] base_ff, base_in;
   logic [REG_W-1:0] result_ff, result_in;
   logic             last_ff, last_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [REG_W-1:0] rsp_value_ff;
   logic             rsp_last_ff;
   logic             out_load;
   logic             mod_small;

   logic             mm_start;
   logic [REG_W-1:0] mm_a;
   logic [REG_W-1:0] mm_b;
   logic             mm_done;
   logic [REG_W-1:0] mm_prod;

   rbme_mulmod #(
      .WIDTH (REG_W)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .a       (mm_a),
      .b       (mm_b),
      .modulus (modulus_ff),
      .done    (mm_done),
      .prod    (mm_prod)
   );

   assign mod_small = modulus_ff < REG_W'(2);
   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in  = state_ff;
      exp_in    = exp_ff;
      cnt_in    = cnt_ff;
      base_in   = base_ff;
      result_in = result_ff;
      last_in   = last_ff;
      mm_start  = 1'b0;
      mm_a      = mm_prod;
      mm_b      = mm_prod;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_in = req_last_char;
               if (mod_small) begin
                  result_in = '0;
                  state_in  = ST_DONE;
               end else begin
                  mm_start = 1'b1;
                  mm_a     = REG_W'(1);
                  mm_b     = REG_W'(req_plain_char);
                  state_in = ST_BASE;
               end
            end
         end
         ST_BASE: begin
            if (mm_done) begin
               base_in   = mm_prod;
               result_in = REG_W'(1);
               exp_in    = exponent_ff;
               cnt_in    = CNT_W'(REG_W);
               mm_start  = 1'b1;
               mm_a      = REG_W'(1);
               mm_b      = REG_W'(1);
               state_in  = ST_SQR;
            end
         end
         ST_SQR: begin
            if (mm_done) begin
               result_in = mm_prod;
               if (exp_ff[REG_W-1]) begin
                  mm_start = 1'b1;
                  mm_b     = base_ff;
                  state_in = ST_MUL;
               end else begin
                  exp_in = exp_ff << 1;
                  cnt_in = cnt_ff - CNT_W'(1);
                  if (cnt_ff == CNT_W'(1)) begin
                     state_in = ST_DONE;
                  end else begin
                     mm_start = 1'b1;
                     state_in = ST_SQR;
                  end
               end
            end
         end
         ST_MUL: begin
            if (mm_done) begin
               result_in = mm_prod;
               exp_in    = exp_ff << 1;
               cnt_in    = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = ST_DONE;
               end else begin
                  mm_start = 1'b1;
                  state_in = ST_SQR;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      exp_ff    <= exp_in;
      cnt_ff    <= cnt_in;
      base_ff   <= base_in;
      result_ff <= result_in;
      last_ff   <= last_in;
      if (out_load) begin
         rsp_value_ff <= result_ff;
         rsp_last_ff  <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= REG_W'(RST_EXPONENT);
         modulus_ff  <= REG_W'(RST_MODULUS);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EXPONENT: exponent_ff <= csr_data[REG_W-1:0];
            CSR_MODULUS:  modulus_ff  <= csr_data[REG_W-1:0];
            default:      ;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cipher_value = CIPHER_W'(rsp_value_ff);
   assign rsp_last_out     = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      mm_done |-> (state_ff == ST_BASE || state_ff == ST_SQR || state_ff == ST_MUL))
      else $error("Multiplier finished outside an exponentiation step.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BASE || state_ff == ST_SQR || state_ff == ST_MUL) |-> !mod_small)
      else $error("Exponentiation running with a modulus below two.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQR || state_ff == ST_MUL) |-> (result_ff < modulus_ff))
      else $error("Running result is not reduced below the modulus.");

endmodule

// ===== test/rsa_byte_modular_exponentiation_top_tb.sv =====
// Self-checking testbench for the RSA byte exponentiation top level.
`timescale 1ns / 1ps

module rsa_byte_modular_exponentiation_top_tb;
   import rbme_pkg::*;

   localparam int HOLD_CYCLES   = 15000;
   localparam int SETTLE_CYCLES = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNUSED = CSR_MODULUS + CSR_INDEX_W'(1);

   typedef struct {
      logic [CIPHER_W-1:0] cipher;
      logic                last;
   } cipher_beat_type;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [CHAR_W-1:0]      req_plain_char = '0;
   logic                   req_last_char  = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b1;
   logic [CIPHER_W-1:0]    rsp_cipher_value;
   logic                   rsp_last_out;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_data       = '0;

   logic [CSR_DATA_W-1:0]  key_exponent   = RST_EXPONENT;
   logic [CSR_DATA_W-1:0]  key_modulus    = RST_MODULUS;
   cipher_beat_type        pending_ciphers[$];
   int                     error_count    = 0;
   int                     req_gap_pct    = 0;
   int                     rsp_stall_pct  = 0;
   logic                   rsp_hold       = 1'b0;
   event                   hold_ev;

   rsa_byte_modular_exponentiation_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_plain_char   (req_plain_char),
      .req_last_char    (req_last_char),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cipher_value (rsp_cipher_value),
      .rsp_last_out     (rsp_last_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #80_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [CIPHER_W-1:0] rsa_encrypt(input logic [CHAR_W-1:0] ch,
                                                       input logic [CSR_DATA_W-1:0] expo,
                                                       input logic [CSR_DATA_W-1:0] modulus);
      logic [63:0] acc;
      logic [63:0] base;
      if (modulus < 2)
         return '0;
      base = ch % modulus;
      acc  = 64'd1;
      for (int i = CSR_DATA_W - 1; i >= 0; i--) begin
         acc = (acc * acc) % modulus;
         if (expo[i])
            acc = (acc * base) % modulus;
      end
      return acc[CIPHER_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      cipher_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_ciphers.size() == 0) begin
            report_mismatch("unexpected beat", rsp_cipher_value, '0);
         end else begin
            want = pending_ciphers.pop_front();
            if (rsp_cipher_value !== want.cipher)
               report_mismatch("cipher_value", rsp_cipher_value, want.cipher);
            if (rsp_last_out !== want.last)
               report_mismatch("last_out", rsp_last_out, want.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else if (rsp_hold)
         rsp_stall <= 1'b1;
      else
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   initial begin
      forever begin
         @(hold_ev);
         rsp_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   task automatic encrypt_char(input logic [CHAR_W-1:0] ch, input logic last);
      cipher_beat_type beat;
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_plain_char <= ch;
      req_last_char  <= last;
      do @(posedge clock); while (req_stall);
      beat.cipher = rsa_encrypt(ch, key_exponent, key_modulus);
      beat.last   = last;
      pending_ciphers = {pending_ciphers, beat};
   endtask

   task automatic wait_for_ciphers();
      req_valid <= 1'b0;
      while (pending_ciphers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_EXPONENT)
         key_exponent = value;
      else if (idx == CSR_MODULUS)
         key_modulus = value;
      @(posedge clock);
   endtask

   task automatic set_key(input logic [CSR_DATA_W-1:0] expo,
                          input logic [CSR_DATA_W-1:0] modulus);
      wait_for_ciphers();
      csr_write(CSR_EXPONENT, expo);
      csr_write(CSR_MODULUS, modulus);
   endtask

   task automatic test_reset_key();
      encrypt_char(8'd0, 1'b0);
      encrypt_char(8'd1, 1'b0);
      encrypt_char(8'd255, 1'b0);
      encrypt_char(8'h80, 1'b0);
      encrypt_char(8'h7F, 1'b0);
      encrypt_char(8'd65, 1'b1);
      wait_for_ciphers();
   endtask

   task automatic test_special_keys();
      // A zero exponent gives one, even for a zero character.
      set_key(32'd0, 32'd3233);
      encrypt_char(8'd0, 1'b0);
      encrypt_char(8'd200, 1'b1);
      // Moduli of zero and one give a zero residue.
      set_key(32'd3, 32'd0);
      encrypt_char(8'd255, 1'b0);
      encrypt_char(8'd7, 1'b1);
      set_key(32'd5, 32'd1);
      encrypt_char(8'd9, 1'b1);
      set_key('1, 32'd2);
      encrypt_char(8'd0, 1'b0);
      encrypt_char(8'd1, 1'b0);
      encrypt_char(8'd255, 1'b1);
      set_key('1, '1);
      encrypt_char(8'd255, 1'b0);
      encrypt_char(8'd2, 1'b1);
      // Characters at or above the modulus are reduced first.
      set_key(32'd65537, 32'd97);
      encrypt_char(8'd97, 1'b0);
      encrypt_char(8'd194, 1'b0);
      encrypt_char(8'd255, 1'b0);
      encrypt_char(8'd96, 1'b1);
      // Writes to unused indexes leave the key alone.
      wait_for_ciphers();
      csr_write(CSR_INDEX_W'($urandom_range(255, CSR_FIRST_UNUSED)), $urandom());
      csr_write('1, $urandom());
      encrypt_char(8'd200, 1'b1);
      wait_for_ciphers();
   endtask

   task automatic test_backpressure();
      int saved_gap;
      saved_gap = req_gap_pct;
      req_gap_pct = 0;
      set_key(32'd17, 32'd3233);
      -> hold_ev;
      for (int n = 0; n < 6; n++)
         encrypt_char(CHAR_W'($urandom_range(255)), 1'(n == 5));
      wait_for_ciphers();
      req_gap_pct = saved_gap;
   endtask

   task automatic test_random_keys(input int count);
      logic [CSR_DATA_W-1:0] expo;
      logic [CSR_DATA_W-1:0] modulus;
      for (int n = 0; n < count; n++) begin
         if (n % 17 == 0) begin
            case ($urandom_range(7))
               0:       expo = $urandom_range(3, 0);
               1, 2:    expo = $urandom_range(65537, 2);
               default: expo = $urandom();
            endcase
            case ($urandom_range(7))
               0:       modulus = $urandom_range(1, 0);
               1, 2:    modulus = $urandom_range(300, 2);
               3:       modulus = {1'b1, 31'($urandom())};
               default: modulus = $urandom();
            endcase
            set_key(expo, modulus);
         end
         encrypt_char(CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
      end
      wait_for_ciphers();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      req_gap_pct   = 32;
      rsp_stall_pct = 75;
      test_reset_key();
      test_special_keys();
      test_backpressure();
      test_random_keys(85);
      req_gap_pct   = 75;
      rsp_stall_pct = 32;
      test_random_keys(85);
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      test_random_keys(85);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rbme_pkg.sv
rtl/rbme_mulmod.sv
rtl/rsa_byte_modular_exponentiation_top.sv
test/rsa_byte_modular_exponentiation_top_tb.sv
